// File: rtl/core/vector3_length_normalize_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vector length and normalisation block
// Shared property shapes for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_LENGTH_NORMALIZE_ASSERT_SVH
`define VECTOR3_LENGTH_NORMALIZE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VLN_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vln check failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define VLN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vln check failed: next-cycle implication");

`endif

// File: rtl/core/vln_pkg.sv
// ----------------------------------------------------------------------------
// vln_pkg
// Widths, command codes, pipeline depths and the saturation helper shared by
// the vector length and normalisation block.
// ----------------------------------------------------------------------------
package vln_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DATA_W     = 32;
   localparam int CMD_W      = 2;
   localparam int SUM_W      = 64;
   localparam int LANES      = 3;
   localparam int ROOT_STEPS = 32;
   // Quotient bits kept by the divider; anything above is flagged as overflow.
   localparam int DIV_STEPS  = 33;
   // Registers from the lane entry register up to the arrival of the length:
   // the square register, the sum register and one per root step.
   localparam int DELAY_STAGES = ROOT_STEPS + 2;
   // Valid bits from the input register up to the last divider step.
   localparam int PIPE_DEPTH = 1 + DELAY_STAGES + DIV_STEPS;

   localparam logic [CMD_W-1:0] CMD_LENGTH     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_NORMALIZE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SET_LENGTH = 2'd2;
   localparam logic [CMD_W-1:0] CMD_SCALE      = 2'd3;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              sat;
   } lane_result_type;

   // Applies a sign to a magnitude and clips it to the signed 32-bit range.
   function automatic lane_result_type sat_apply(input logic neg, input logic [63:0] mag,
                                                 input logic ovf);
      lane_result_type r;
      logic            big;
      big = ovf || (neg ? (mag > 64'h0000_0000_8000_0000)
                        : (mag > 64'h0000_0000_7FFF_FFFF));
      r.sat = big;
      if (neg) begin
         r.value = big ? 32'h8000_0000 : (32'd0 - mag[DATA_W-1:0]);
      end else begin
         r.value = big ? 32'h7FFF_FFFF : mag[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/core/vln_channels.sv
// ----------------------------------------------------------------------------
// vln channels
// Valid/ready channels for request and response items of the block.
// ----------------------------------------------------------------------------
interface vln_req_if import vln_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [DATA_W-1:0] in_x;
   logic [DATA_W-1:0] in_y;
   logic [DATA_W-1:0] in_z;
   logic [DATA_W-1:0] amount;

   modport source (output valid, command, in_x, in_y, in_z, amount, input ready);
   modport sink   (input valid, command, in_x, in_y, in_z, amount, output ready);
endinterface

interface vln_rsp_if import vln_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] out_x;
   logic [DATA_W-1:0] out_y;
   logic [DATA_W-1:0] out_z;
   logic [DATA_W-1:0] vec_length;
   logic              was_zero;
   logic              saturated;

   modport source (output valid, out_x, out_y, out_z, vec_length, was_zero, saturated,
                   input ready);
   modport sink   (input valid, out_x, out_y, out_z, vec_length, was_zero, saturated,
                   output ready);
endinterface

// File: rtl/core/vector3_length_normalize.sv
// ----------------------------------------------------------------------------
// vector3_length_normalize
// Length, normalisation, rescaling and scaling of a signed fixed-point vector,
// one lane per component with a shared square-root pipeline.
// ----------------------------------------------------------------------------
//  channel  direction  handshake    payload
//  req_ch   in         valid/ready  command, in_x, in_y, in_z, amount
//  rsp_ch   out        valid/ready  out_x, out_y, out_z, vec_length, was_zero, saturated
//
// One item is accepted per cycle while no response stall holds the pipeline;
// each response comes after 32 square-root steps and 33 divider steps in series.
// Reset clears the valid bits of the pipeline and the response register.
// When a response waits and is not taken the whole pipeline holds and
// req_ch.ready drops; it rises again in the cycle the response is taken.
// ----------------------------------------------------------------------------
module vector3_length_normalize import vln_pkg::*; (
   input logic      clock,
   input logic      reset,
   vln_req_if.sink  req_ch,
   vln_rsp_if.source rsp_ch
);

   logic              en;
   logic              vld_ff [PIPE_DEPTH];
   logic [CMD_W-1:0]  cmd_ff;
   logic [DATA_W-1:0] comp_ff [LANES];
   logic [DATA_W-1:0] amount_ff;
   logic [SUM_W-1:0]  square [LANES];
   lane_result_type   lane_res [LANES];
   logic [DATA_W-1:0] vec_len;
   logic [DATA_W-1:0] len_ff [DIV_STEPS];

   logic              rsp_valid_ff;
   logic [DATA_W-1:0] out_ff [LANES];
   logic [DATA_W-1:0] len_out_ff;
   logic              zero_ff;
   logic              sat_ff;
   logic              zero_in;
   logic              sat_in;

   // The pipeline moves whenever the response register can take a new item.
   assign en           = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIPE_DEPTH; k++) begin
            vld_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_ch.valid;
         for (int k = 1; k < PIPE_DEPTH; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         rsp_valid_ff <= vld_ff[PIPE_DEPTH-1];
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (en) begin
         cmd_ff     <= req_ch.command;
         comp_ff[0] <= req_ch.in_x;
         comp_ff[1] <= req_ch.in_y;
         comp_ff[2] <= req_ch.in_z;
         amount_ff  <= req_ch.amount;
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      vln_lane u_lane (
         .clock   (clock),
         .en      (en),
         .command (cmd_ff),
         .comp    (comp_ff[l]),
         .amount  (amount_ff),
         .vec_len (vec_len),
         .square  (square[l]),
         .result  (lane_res[l])
      );
   end

   vln_sqrt u_sqrt (
      .clock   (clock),
      .en      (en),
      .square  (square),
      .vec_len (vec_len)
   );

   // The length travels alongside the divider stages.
   always_ff @(posedge clock) begin
      if (en) begin
         len_ff[0] <= vec_len;
         for (int k = 1; k < DIV_STEPS; k++) begin
            len_ff[k] <= len_ff[k-1];
         end
      end
   end

   // Merge: a zero vector forces a zero result and clears the clip flag.
   assign zero_in = (len_ff[DIV_STEPS-1] == '0);
   assign sat_in  = !zero_in && (lane_res[0].sat || lane_res[1].sat || lane_res[2].sat);

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < LANES; l++) begin
            out_ff[l] <= zero_in ? '0 : lane_res[l].value;
         end
         len_out_ff <= len_ff[DIV_STEPS-1];
         zero_ff    <= zero_in;
         sat_ff     <= sat_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_x      = out_ff[0];
   assign rsp_ch.out_y      = out_ff[1];
   assign rsp_ch.out_z      = out_ff[2];
   assign rsp_ch.vec_length = len_out_ff;
   assign rsp_ch.was_zero   = zero_ff;
   assign rsp_ch.saturated  = sat_ff;

endmodule

// File: rtl/core/vln_sqrt.sv
// ----------------------------------------------------------------------------
// vln_sqrt
// Sums the three lane squares and takes the integer square root, one root
// bit per pipeline stage.
// ----------------------------------------------------------------------------
module vln_sqrt import vln_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [SUM_W-1:0]  square [LANES],
   output logic [DATA_W-1:0] vec_len
);

   logic [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:0]  sum_in;
   logic [SUM_W-1:0]  rem_ff  [ROOT_STEPS];
   logic [SUM_W-1:0]  rem_in  [ROOT_STEPS];
   logic [DATA_W-1:0] root_ff [ROOT_STEPS];
   logic [DATA_W-1:0] root_in [ROOT_STEPS];

   // Sum of squares; three values of at most 2^62 fit in 64 bits.
   assign sum_in = square[0] + square[1] + square[2];

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= sum_in;
      end
   end

   // Each step tries to set the next lower root bit.
   for (genvar s = 0; s < ROOT_STEPS; s++) begin : g_step
      logic [SUM_W-1:0]  rem_cur;
      logic [DATA_W-1:0] root_cur;
      logic [SUM_W:0]    trial;

      if (s == 0) begin : g_first
         assign rem_cur  = sum_ff;
         assign root_cur = '0;
      end else begin : g_next
         assign rem_cur  = rem_ff[s-1];
         assign root_cur = root_ff[s-1];
      end

      always_comb begin
         trial = ({{(SUM_W+1-DATA_W){1'b0}}, root_cur} << (ROOT_STEPS - s))
               + ((SUM_W+1)'(1) << (2 * (ROOT_STEPS - 1 - s)));
         if ({1'b0, rem_cur} >= trial) begin
            rem_in[s]  = rem_cur - trial[SUM_W-1:0];
            root_in[s] = root_cur | (DATA_W'(1) << (ROOT_STEPS - 1 - s));
         end else begin
            rem_in[s]  = rem_cur;
            root_in[s] = root_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in[s];
            root_ff[s] <= root_in[s];
         end
      end
   end

   assign vec_len = root_ff[ROOT_STEPS-1];

endmodule

// File: rtl/core/vln_lane.sv
// ----------------------------------------------------------------------------
// vln_lane
// One vector component: magnitude, square, product with the amount, and a
// pipelined restoring divider by the vector length.
// ----------------------------------------------------------------------------
module vln_lane import vln_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [CMD_W-1:0]  command,
   input  logic [DATA_W-1:0] comp,
   input  logic [DATA_W-1:0] amount,
   input  logic [DATA_W-1:0] vec_len,
   output logic [SUM_W-1:0]  square,
   output lane_result_type   result
);

   logic              comp_neg;
   logic              amt_neg;
   logic [DATA_W-1:0] comp_mag;
   logic [DATA_W-1:0] amt_mag;
   logic [SUM_W-1:0]  prod;
   logic [SUM_W-1:0]  sq_in;
   logic [SUM_W-1:0]  num_in;
   logic              neg_in;
   logic              div_in;
   lane_result_type   byp_in;

   logic [SUM_W-1:0]  sq_ff;
   logic [SUM_W-1:0]  dl_num_ff [DELAY_STAGES];
   logic              dl_neg_ff [DELAY_STAGES];
   logic              dl_div_ff [DELAY_STAGES];
   lane_result_type   dl_byp_ff [DELAY_STAGES];

   logic [SUM_W-1:0]     dv_rem_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] dv_q_ff   [DIV_STEPS];
   logic [DATA_W-1:0]    dv_len_ff [DIV_STEPS];
   logic                 dv_ovf_ff [DIV_STEPS];
   logic                 dv_neg_ff [DIV_STEPS];
   logic                 dv_div_ff [DIV_STEPS];
   lane_result_type      dv_byp_ff [DIV_STEPS];
   logic [SUM_W-1:0]     dv_rem_in [DIV_STEPS];
   logic [DIV_STEPS-1:0] dv_q_in   [DIV_STEPS];

   // Entry stage: magnitudes, both products and the per-command work.
   always_comb begin
      comp_neg = comp[DATA_W-1];
      amt_neg  = amount[DATA_W-1];
      comp_mag = comp_neg ? (DATA_W'(0) - comp) : comp;
      amt_mag  = amt_neg ? (DATA_W'(0) - amount) : amount;
      sq_in    = {{(SUM_W-DATA_W){1'b0}}, comp_mag} * {{(SUM_W-DATA_W){1'b0}}, comp_mag};
      prod     = {{(SUM_W-DATA_W){1'b0}}, comp_mag} * {{(SUM_W-DATA_W){1'b0}}, amt_mag};
      num_in   = prod;
      neg_in   = comp_neg ^ amt_neg;
      div_in   = 1'b0;
      byp_in   = '{value: comp, sat: 1'b0};
      case (command)
         CMD_NORMALIZE: begin
            num_in = {{(SUM_W-DATA_W){1'b0}}, comp_mag} << FRAC_BITS;
            neg_in = comp_neg;
            div_in = 1'b1;
         end
         CMD_SET_LENGTH: begin
            div_in = 1'b1;
         end
         CMD_SCALE: begin
            byp_in = sat_apply(comp_neg ^ amt_neg, prod >> FRAC_BITS, 1'b0);
         end
         default: begin
            byp_in = '{value: comp, sat: 1'b0};
         end
      endcase
   end

   // Entry register and the delay line that waits for the length.
   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff        <= sq_in;
         dl_num_ff[0] <= num_in;
         dl_neg_ff[0] <= neg_in;
         dl_div_ff[0] <= div_in;
         dl_byp_ff[0] <= byp_in;
         for (int d = 1; d < DELAY_STAGES; d++) begin
            dl_num_ff[d] <= dl_num_ff[d-1];
            dl_neg_ff[d] <= dl_neg_ff[d-1];
            dl_div_ff[d] <= dl_div_ff[d-1];
            dl_byp_ff[d] <= dl_byp_ff[d-1];
         end
      end
   end

   assign square = sq_ff;

   // Divider: one quotient bit per stage, most significant first.
   for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
      logic [SUM_W-1:0]     rem_cur;
      logic [DIV_STEPS-1:0] q_cur;
      logic [DATA_W-1:0]    len_cur;
      logic                 ovf_cur;
      logic                 neg_cur;
      logic                 div_cur;
      lane_result_type      byp_cur;
      logic [SUM_W:0]       trial;

      if (s == 0) begin : g_first
         assign rem_cur = dl_num_ff[DELAY_STAGES-1];
         assign q_cur   = '0;
         assign len_cur = vec_len;
         // A quotient of 2^33 or more always saturates.
         assign ovf_cur = (dl_num_ff[DELAY_STAGES-1] >> DIV_STEPS)
                          >= {{(SUM_W-DATA_W){1'b0}}, vec_len};
         assign neg_cur = dl_neg_ff[DELAY_STAGES-1];
         assign div_cur = dl_div_ff[DELAY_STAGES-1];
         assign byp_cur = dl_byp_ff[DELAY_STAGES-1];
      end else begin : g_next
         assign rem_cur = dv_rem_ff[s-1];
         assign q_cur   = dv_q_ff[s-1];
         assign len_cur = dv_len_ff[s-1];
         assign ovf_cur = dv_ovf_ff[s-1];
         assign neg_cur = dv_neg_ff[s-1];
         assign div_cur = dv_div_ff[s-1];
         assign byp_cur = dv_byp_ff[s-1];
      end

      always_comb begin
         trial = {{(SUM_W+1-DATA_W){1'b0}}, len_cur} << (DIV_STEPS - 1 - s);
         if (!ovf_cur && ({1'b0, rem_cur} >= trial)) begin
            dv_rem_in[s] = rem_cur - trial[SUM_W-1:0];
            dv_q_in[s]   = q_cur | (DIV_STEPS'(1) << (DIV_STEPS - 1 - s));
         end else begin
            dv_rem_in[s] = rem_cur;
            dv_q_in[s]   = q_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_rem_ff[s] <= dv_rem_in[s];
            dv_q_ff[s]   <= dv_q_in[s];
            dv_len_ff[s] <= len_cur;
            dv_ovf_ff[s] <= ovf_cur;
            dv_neg_ff[s] <= neg_cur;
            dv_div_ff[s] <= div_cur;
            dv_byp_ff[s] <= byp_cur;
         end
      end
   end

   // Sign and clip the quotient, or pass the precomputed result.
   assign result = dv_div_ff[DIV_STEPS-1]
                 ? sat_apply(dv_neg_ff[DIV_STEPS-1],
                             {{(SUM_W-DIV_STEPS){1'b0}}, dv_q_ff[DIV_STEPS-1]},
                             dv_ovf_ff[DIV_STEPS-1])
                 : dv_byp_ff[DIV_STEPS-1];

endmodule

// File: rtl/core/vln_checker.sv
// ----------------------------------------------------------------------------
// vln_checker
// Port-level checks on the response channel of the block, bound to the top.
// ----------------------------------------------------------------------------
`include "vector3_length_normalize_assert.svh"

module vln_checker import vln_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DATA_W-1:0] out_x,
   input logic [DATA_W-1:0] out_y,
   input logic [DATA_W-1:0] out_z,
   input logic [DATA_W-1:0] vec_length,
   input logic              was_zero,
   input logic              saturated
);

   // A waiting item stays offered.
   `VLN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // A stalled response stops new items coming in.
   `VLN_ASSERT_IMPLY(a_stall_blocks, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   // The zero flag agrees with the length.
   `VLN_ASSERT_IMPLY(a_zero_len, clock, reset, rsp_valid, was_zero == (vec_length == '0))
   // A zero vector gives a zero, unclipped result.
   `VLN_ASSERT_IMPLY(a_zero_out, clock, reset, rsp_valid && was_zero, out_x == '0 && out_y == '0 && out_z == '0 && !saturated)

endmodule

bind vector3_length_normalize vln_checker u_vln_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .out_x      (rsp_ch.out_x),
   .out_y      (rsp_ch.out_y),
   .out_z      (rsp_ch.out_z),
   .vec_length (rsp_ch.vec_length),
   .was_zero   (rsp_ch.was_zero),
   .saturated  (rsp_ch.saturated)
);

// File: dv/vln_tb_channels.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench channel note
// The block's own channel interfaces (vln_req_if, vln_rsp_if) are reused by
// the testbench; this file holds the item types shared by checker and top.
// ----------------------------------------------------------------------------
package vln_tb_pkg;
   import vln_pkg::*;

   // One request item as the stimulus builds it.
   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [DATA_W-1:0] in_x;
      logic [DATA_W-1:0] in_y;
      logic [DATA_W-1:0] in_z;
      logic [DATA_W-1:0] amount;
   } vec_item_type;

   // One response item as predicted or observed.
   typedef struct packed {
      logic [DATA_W-1:0] out_x;
      logic [DATA_W-1:0] out_y;
      logic [DATA_W-1:0] out_z;
      logic [DATA_W-1:0] vec_length;
      logic              was_zero;
      logic              saturated;
   } vec_result_type;
endpackage

// File: dv/vln_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Vector length checker
// Watches both channels, computes the expected response of every accepted
// item and compares each response with the oldest expectation.
// ----------------------------------------------------------------------------
module vln_tb_checker import vln_pkg::*; import vln_tb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   vln_req_if       req_ch,
   vln_rsp_if       rsp_ch,
   output int       fail_count,
   output int       pending_count
);

   vec_result_type pending_results[$];

   // Integer square root of a 64-bit sum, rounded down.
   function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] bitv;
      rem  = v;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem  = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root[31:0];
   endfunction

   // Signs a magnitude and clips it to the signed 32-bit range.
   function automatic logic [31:0] clip_signed(input logic neg, input logic [63:0] q,
                                               inout logic sat);
      if (neg) begin
         if (q > 64'h8000_0000) begin
            sat = 1'b1;
            return 32'h8000_0000;
         end
         return 32'd0 - q[31:0];
      end
      if (q > 64'h7FFF_FFFF) begin
         sat = 1'b1;
         return 32'h7FFF_FFFF;
      end
      return q[31:0];
   endfunction

   function automatic logic [63:0] magnitude(input logic [31:0] v);
      return v[31] ? {32'd0, 32'd0 - v} : {32'd0, v};
   endfunction

   // Expected response for one request item.
   function automatic vec_result_type predict_vector(input vec_item_type it);
      vec_result_type r;
      logic [31:0] comp[3];
      logic [31:0] res[3];
      logic [63:0] sum;
      logic [63:0] m;
      logic [63:0] amag;
      logic [31:0] len;
      logic        zero;
      logic        sat;
      logic        aneg;
      comp[0] = it.in_x;
      comp[1] = it.in_y;
      comp[2] = it.in_z;
      amag = magnitude(it.amount);
      aneg = it.amount[31];
      sum = 0;
      sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         m = magnitude(comp[i]);
         sum = sum + m * m;
      end
      len  = floor_sqrt(sum);
      zero = (sum == 0);
      for (int i = 0; i < 3; i++) begin
         m = magnitude(comp[i]);
         if (zero) begin
            res[i] = 0;
         end else begin
            case (it.command)
               CMD_LENGTH:     res[i] = comp[i];
               CMD_NORMALIZE:  res[i] = clip_signed(comp[i][31], (m << FRAC_BITS) / len, sat);
               CMD_SET_LENGTH: res[i] = clip_signed(comp[i][31] ^ aneg, (m * amag) / len, sat);
               default:        res[i] = clip_signed(comp[i][31] ^ aneg,
                                                    (m * amag) >> FRAC_BITS, sat);
            endcase
         end
      end
      r.out_x      = res[0];
      r.out_y      = res[1];
      r.out_z      = res[2];
      r.vec_length = len;
      r.was_zero   = zero;
      r.saturated  = sat;
      return r;
   endfunction

   // Record expectations on accepted requests and check accepted responses.
   always @(posedge clock) begin
      vec_item_type   it;
      vec_result_type seen;
      vec_result_type want;
      if (reset) begin
         fail_count    <= 0;
         pending_count <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            it = {req_ch.command, req_ch.in_x, req_ch.in_y, req_ch.in_z, req_ch.amount};
            pending_results.push_back(predict_vector(it));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen = {rsp_ch.out_x, rsp_ch.out_y, rsp_ch.out_z, rsp_ch.vec_length,
                    rsp_ch.was_zero, rsp_ch.saturated};
            if (pending_results.size() == 0) begin
               if (fail_count < 10)
                  $display("Unexpected response item: %h", seen);
               fail_count <= fail_count + 1;
            end else begin
               want = pending_results.pop_front();
               if (seen !== want) begin
                  if (fail_count < 10)
                     $display("Mismatch: expected x=%h y=%h z=%h len=%h zero=%b sat=%b,",
                              want.out_x, want.out_y, want.out_z, want.vec_length,
                              want.was_zero, want.saturated,
                              " got x=%h y=%h z=%h len=%h zero=%b sat=%b",
                              seen.out_x, seen.out_y, seen.out_z, seen.vec_length,
                              seen.was_zero, seen.saturated);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= pending_results.size();
      end
   end

endmodule

// File: dv/tb_vector3_length_normalize.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Vector length block testbench
// Drives directed corner vectors and random items of every command with random
// gaps and response stalls, including one long stall; the checker judges.
// ----------------------------------------------------------------------------
module tb_vector3_length_normalize;
   import vln_pkg::*;
   import vln_tb_pkg::*;

   localparam int RANDOM_ITEMS = 1150;
   localparam int CYCLE_LIMIT  = 400000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   cycle_count;
   bit   idle_free;
   bit   long_hold;

   vln_req_if req_ch ();
   vln_rsp_if rsp_ch ();

   vector3_length_normalize dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   vln_tb_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A random component: mostly small, sometimes full range or extreme.
   function automatic logic [31:0] pick_component();
      case ($urandom_range(0, 5))
         0:       return $urandom();
         1:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         2:       return 32'd0;
         3:       return $urandom_range(0, 1) ? $urandom_range(0, 255)
                                              : 32'd0 - $urandom_range(0, 255);
         default: return $signed($urandom()) >>> $urandom_range(4, 20);
      endcase
   endfunction

   // Offers one item and waits until the block accepts it; valid stays high
   // afterwards so that items can follow back to back.
   task automatic send_item(input vec_item_type it);
      while (!idle_free && $urandom_range(0, 99) < 26) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.command <= it.command;
      req_ch.in_x    <= it.in_x;
      req_ch.in_y    <= it.in_y;
      req_ch.in_z    <= it.in_z;
      req_ch.amount  <= it.amount;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Response side: random stalls, one long hold-off, a stretch without stalls.
   always @(posedge clock) begin
      if (reset)
         rsp_ch.ready <= 1'b0;
      else if (long_hold)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= idle_free || ($urandom_range(0, 99) >= 26);
   end

   // Cycle counter and timeout.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      vec_item_type it;
      logic [31:0] ext[4];
      ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF};
      cycle_count    = 0;
      idle_free      = 1'b0;
      long_hold      = 1'b0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.command = CMD_LENGTH;
      req_ch.in_x    = 0;
      req_ch.in_y    = 0;
      req_ch.in_z    = 0;
      req_ch.amount  = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part: zero vector for all commands, extreme components, signs.
      for (int c = 0; c < 4; c++) begin
         it = {c[1:0], 32'd0, 32'd0, 32'd0, 32'h0001_0000};
         send_item(it);
         it = {c[1:0], ext[c], ext[(c + 1) % 4], ext[(c + 2) % 4], ext[(c + 3) % 4]};
         send_item(it);
         it = {c[1:0], 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
         send_item(it);
         it = {c[1:0], 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
         send_item(it);
         it = {c[1:0], 32'd1, 32'hFFFF_FFFF, 32'd0, 32'hFFFE_0000};
         send_item(it);
      end
      it = {CMD_SET_LENGTH, 32'h0003_0000, 32'h0004_0000, 32'd0, 32'hFFFB_0000};
      send_item(it);

      // Random part with a long response hold-off and a stall-free stretch.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 300) begin
            long_hold <= 1'b1;
            fork
               begin
                  repeat (300) @(posedge clock);
                  long_hold <= 1'b0;
               end
            join_none
         end
         if (n == 700) idle_free <= 1'b1;
         if (n == 900) idle_free <= 1'b0;
         it.command = CMD_W'($urandom_range(0, 3));
         it.in_x    = pick_component();
         it.in_y    = pick_component();
         it.in_z    = pick_component();
         it.amount  = pick_component();
         send_item(it);
      end
      req_ch.valid <= 1'b0;

      // Drain and let the pipeline settle.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
